/* hdl/wsr_pkg.sv */
// Shared types and constants for the wavetable sound register block.
// Used by wsr_ctrl, wsr_datapath and wavetable_sound_registers.
package wsr_pkg;

    localparam int CHANNELS_DEF     = 8;
    localparam int PHASE_FRAC_DEF   = 18;
    localparam int SPEED_FRAC_DEF   = 20;
    localparam int VOLUME_SCALE_DEF = 8;

    localparam int RATE_W = 32;
    localparam int FREQ_W = 18;

    // register RAM map
    localparam logic [6:0] CHAN_BASE  = 7'h40;
    localparam logic [6:0] COUNT_ADDR = 7'h7F;
    localparam logic [2:0] CR_FREQ_LO  = 3'd0;
    localparam logic [2:0] CR_FREQ_MID = 3'd2;
    localparam logic [2:0] CR_LENGTH   = 3'd4;
    localparam logic [2:0] CR_OFFSET   = 3'd6;
    localparam logic [2:0] CR_VOLUME   = 3'd7;

    typedef enum logic [1:0] {
        FN_ADDR  = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_TICK  = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] mix_sample;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DONE,
        S_CHECK,
        S_DIV,
        S_ADD,
        S_MOD,
        S_WRD,
        S_WACC
    } t_state;

    typedef struct packed {
        logic accept;    // transaction taken this cycle
        logic next_ch;   // move to next channel
        logic div_load;  // start timer division
        logic step;      // one shift-subtract step
        logic tmr_mul;   // write timer, form quotient * frequency
        logic mod_load;  // start phase modulo
        logic ph_wr;     // write new phase
        logic wave_rd;   // read wave byte
        logic wave_acc;  // accumulate wave * volume
    } t_cmd;

    typedef struct packed {
        logic ch_end;
        logic ch_active;
        logic ch_runs;
        logic div_done;
    } t_sts;

endpackage

/* hdl/wavetable_sound_registers.sv */
// Wavetable sound unit: up to eight wavetable channels behind a register RAM.
// Start a transaction with i_start while o_busy is low; i_in carries func
// (address write, data write, data read, sample tick) and a data byte.
// Every transaction returns exactly one result on o_out, marked by o_valid
// for one cycle; the receiver cannot stall, so the result must be taken then.
// Address write, data write and data read go from S_IDLE to S_DONE, which raises the strobe.
// A sample tick walks channels first_channel..CHANNELS-1 one after another:
// an inactive channel is skipped, an active channel whose phase cannot move
// (no count or no length set) only reads and mixes its wave byte, and a moving
// channel runs the timer division and then the phase modulo on the shared
// shift-subtract unit, whose width W is 14 at default settings.
// o_cfg_ready is always high; rate_step is written on i_cfg_valid; write it only idle (not enforced).
// Synchronous active-low reset resets the configuration and channel registers,
// clears the RAM valid bits (so the RAM reads as zero), sets auto-increment and silences all channels.
// Depends on wsr_pkg, wsr_ctrl and wsr_datapath.
module wavetable_sound_registers #(
    parameter int CHANNELS            = wsr_pkg::CHANNELS_DEF,
    parameter int PHASE_FRACTION_BITS = wsr_pkg::PHASE_FRAC_DEF,
    parameter int SPEED_FRACTION_BITS = wsr_pkg::SPEED_FRAC_DEF,
    parameter int VOLUME_SCALE        = wsr_pkg::VOLUME_SCALE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  wsr_pkg::t_in               i_in,
    output logic                       o_valid,
    output wsr_pkg::t_out              o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wsr_pkg::RATE_W-1:0] i_cfg_data
);
    import wsr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    wsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_in.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    wsr_datapath #(
        .CHANNELS            (CHANNELS),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS),
        .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS),
        .VOLUME_SCALE        (VOLUME_SCALE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

/* hdl/wsr_ctrl.sv */
// Sequencer for the wavetable sound block: handshake and per-channel tick steps.
// Depends on wsr_pkg; drives wsr_datapath through t_cmd.
module wsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  wsr_pkg::t_func i_func,
    input  wsr_pkg::t_sts  i_sts,
    output wsr_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import wsr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_func == FN_TICK) ? S_CHECK : S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            S_CHECK: begin
                if (i_sts.ch_end) begin
                    n_state = S_DONE;
                end else if (!i_sts.ch_active) begin
                    o_cmd.next_ch = 1'b1;
                end else if (i_sts.ch_runs) begin
                    o_cmd.div_load = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.wave_rd = 1'b1;
                    n_state = S_WACC;
                end
            end
            S_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.tmr_mul = 1'b1;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.mod_load = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (!i_sts.div_done) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.ph_wr = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.wave_rd = 1'b1;
                n_state = S_WACC;
            end
            S_WACC: begin
                o_cmd.wave_acc = 1'b1;
                o_cmd.next_ch  = 1'b1;
                n_state = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

/* hdl/wsr_datapath.sv */
// Datapath: register RAM, channel registers, shared shift-subtract divider,
// multiplier and mix accumulator. Depends on wsr_pkg; commanded by wsr_ctrl.
module wsr_datapath #(
    parameter int CHANNELS            = wsr_pkg::CHANNELS_DEF,
    parameter int PHASE_FRACTION_BITS = wsr_pkg::PHASE_FRAC_DEF,
    parameter int SPEED_FRACTION_BITS = wsr_pkg::SPEED_FRAC_DEF,
    parameter int VOLUME_SCALE        = wsr_pkg::VOLUME_SCALE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wsr_pkg::t_in                 i_in,
    input  wsr_pkg::t_cmd                i_cmd,
    input  logic                         i_cfg_we,
    input  logic [wsr_pkg::RATE_W-1:0]   i_cfg_data,
    output wsr_pkg::t_sts                o_sts,
    output wsr_pkg::t_out                o_out
);
    import wsr_pkg::*;

    localparam int PFB     = PHASE_FRACTION_BITS;
    localparam int SFB     = SPEED_FRACTION_BITS;
    localparam int CI_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TIMER_W = SFB + 3;
    localparam int S_W     = RATE_W + 1;
    localparam int Q_W     = S_W - SFB;
    localparam int PHASE_W = PFB + 5;
    localparam int PROD_W  = Q_W + FREQ_W;
    localparam int SUM_W   = ((PROD_W > PHASE_W) ? PROD_W : PHASE_W) + 1;
    localparam int MH_W    = SUM_W - PFB;
    localparam int NUM_W   = (Q_W > MH_W) ? Q_W : MH_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam logic [3:0] NCH = 4'(CHANNELS);
    localparam logic [6:0] VSC = 7'(VOLUME_SCALE);

    // configuration and bus state
    logic [RATE_W-1:0] r_rate_step;
    logic [6:0]        r_ptr;
    logic              r_autoinc;
    logic [3:0]        r_first;
    logic [3:0]        r_count;   // channel count, zero until set
    t_func             r_func;

    // register RAM with valid bits
    logic [7:0] r_mem [128];
    logic       r_mem_vld [128];
    logic [7:0] r_mem_q;
    logic       r_q_vld;
    logic       r_nib_sel;

    // channel registers
    logic [FREQ_W-1:0]  r_freq   [CHANNELS];
    logic [PHASE_W-1:0] r_phase  [CHANNELS];
    logic [TIMER_W-1:0] r_timer  [CHANNELS];
    logic [5:0]         r_len    [CHANNELS];
    logic [7:0]         r_offset [CHANNELS];
    logic [6:0]         r_vol    [CHANNELS];
    logic               r_en     [CHANNELS];
    logic               r_active [CHANNELS];

    // tick working registers
    logic [3:0]        r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [5:0]        r_rem;
    logic [5:0]        r_dvsr;
    logic [CNT_W-1:0]  r_steps;
    logic [SFB-1:0]    r_s_low;
    logic [PFB-1:0]    r_ph_low;
    logic [PROD_W-1:0] r_prod;
    logic [16:0]       r_sum;

    logic        is_write, is_read, wc_ok;
    logic [6:0]  addr;
    logic [2:0]  wc;
    logic [CI_W-1:0] ci;
    logic [CI_W-1:0] wi;
    logic [FREQ_W-1:0] nfreq;
    logic [6:0]  nvol;
    logic        nen;
    logic [5:0]  nlen;
    logic [3:0]  ncount;
    logic [S_W-1:0] s_val;
    logic [SUM_W-1:0] ph_sum;
    logic [6:0]  dv_t;
    logic        dv_ge;
    logic [7:0]  widx;
    logic [6:0]  rd_addr;
    logic        rd_en;
    logic [3:0]  nib;
    logic [5:0]  wave;
    logic [12:0] wprod;
    logic [17:0] acc;

    assign addr     = r_ptr;
    assign wc       = addr[5:3];
    assign is_write = i_cmd.accept && (i_in.func == FN_WRITE);
    assign is_read  = i_cmd.accept && (i_in.func == FN_READ);
    assign wc_ok    = (addr >= CHAN_BASE) && ({1'b0, wc} < NCH);
    assign wi       = wc[CI_W-1:0];
    assign ci       = r_cnt[CI_W-1:0];

    // new channel fields for a data write
    always_comb begin
        nfreq = r_freq[wi];
        nvol  = r_vol[wi];
        nen   = r_en[wi];
        nlen  = 6'd32 - {1'b0, i_in.data[4:2], 2'b00};
        case (addr[2:0])
            CR_FREQ_LO:  nfreq[7:0]   = i_in.data;
            CR_FREQ_MID: nfreq[15:8]  = i_in.data;
            CR_LENGTH: begin
                nfreq[17:16] = i_in.data[1:0];
                nen          = (i_in.data[7:5] != 3'd0);
            end
            CR_VOLUME:   nvol = 7'(i_in.data[3:0] * VSC);
            default: ;
        endcase
    end

    assign ncount = {1'b0, i_in.data[6:4]} + 4'd1;
    assign s_val  = S_W'(r_timer[ci]) + S_W'(r_rate_step);
    assign ph_sum = SUM_W'(r_phase[ci]) + SUM_W'(r_prod);
    assign dv_t   = {r_rem, r_num[NUM_W-1]};
    assign dv_ge  = (dv_t >= {1'b0, r_dvsr});
    assign widx   = r_offset[ci] + {3'b000, r_phase[ci][PHASE_W-1:PFB]};
    assign rd_addr = is_read ? r_ptr : widx[7:1];
    assign rd_en   = is_read || i_cmd.wave_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= '0;
            r_ptr       <= '0;
            r_autoinc   <= 1'b1;
            r_first     <= NCH;
            r_count     <= '0;
            r_func      <= FN_ADDR;
            r_cnt       <= '0;
            r_sum       <= '0;
            for (int i = 0; i < 128; i++) begin
                r_mem_vld[i] <= 1'b0;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                r_freq[i]   <= '0;
                r_phase[i]  <= '0;
                r_timer[i]  <= '0;
                r_len[i]    <= '0;
                r_offset[i] <= '0;
                r_vol[i]    <= '0;
                r_en[i]     <= 1'b0;
                r_active[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_rate_step <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_func <= i_in.func;
                case (i_in.func)
                    FN_ADDR: begin
                        r_ptr     <= i_in.data[6:0];
                        r_autoinc <= i_in.data[7];
                    end
                    FN_WRITE: begin
                        r_mem_vld[addr] <= 1'b1;
                        r_ptr <= addr + {6'd0, r_autoinc};
                        if (wc_ok) begin
                            r_freq[wi]   <= nfreq;
                            r_vol[wi]    <= nvol;
                            r_en[wi]     <= nen;
                            r_active[wi] <= (nvol != '0) && (nfreq != '0) && nen;
                            if (addr[2:0] == CR_OFFSET) begin
                                r_offset[wi] <= i_in.data;
                            end
                            if (addr[2:0] == CR_LENGTH && r_len[wi] != nlen) begin
                                r_len[wi]   <= nlen;
                                r_phase[wi] <= '0;
                            end
                        end
                        if (addr == COUNT_ADDR) begin
                            r_count <= ncount;
                            r_first <= (ncount > NCH) ? 4'd0 : NCH - ncount;
                        end
                    end
                    FN_READ: begin
                        r_ptr <= addr + {6'd0, r_autoinc};
                    end
                    default: begin
                        r_cnt <= r_first;
                        r_sum <= '0;
                    end
                endcase
            end
            if (i_cmd.tmr_mul) begin
                r_timer[ci] <= {r_rem[2:0], r_s_low};
            end
            if (i_cmd.ph_wr) begin
                r_phase[ci] <= {r_rem[4:0], r_ph_low};
            end
            if (i_cmd.wave_acc) begin
                r_sum <= (acc[17:16] != 2'd0) ? 17'h10000 : acc[16:0];
            end
            if (i_cmd.next_ch) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // memory array and registered read
    always_ff @(posedge i_clk) begin
        if (is_write) begin
            r_mem[addr] <= i_in.data;
        end
        if (rd_en) begin
            r_mem_q   <= r_mem[rd_addr];
            r_q_vld   <= r_mem_vld[rd_addr];
            r_nib_sel <= widx[0];
        end
    end

    // shared shift-subtract unit, quotient collects in r_num
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num   <= NUM_W'(s_val >> SFB);
            r_s_low <= s_val[SFB-1:0];
            r_dvsr  <= {2'b00, r_count};
            r_rem   <= '0;
            r_steps <= CNT_W'(NUM_W);
        end else if (i_cmd.mod_load) begin
            r_num    <= NUM_W'(ph_sum >> PFB);
            r_ph_low <= ph_sum[PFB-1:0];
            r_dvsr   <= r_len[ci];
            r_rem    <= '0;
            r_steps  <= CNT_W'(NUM_W);
        end else if (i_cmd.step) begin
            r_rem   <= dv_ge ? 6'(dv_t - {1'b0, r_dvsr}) : dv_t[5:0];
            r_num   <= {r_num[NUM_W-2:0], dv_ge};
            r_steps <= r_steps - CNT_W'(1);
        end
        if (i_cmd.tmr_mul) begin
            r_prod <= PROD_W'(r_num[Q_W-1:0] * r_freq[ci]);
        end
    end

    assign nib   = r_nib_sel ? r_mem_q[7:4] : r_mem_q[3:0];
    assign wave  = r_q_vld ? {nib, 2'b00} : 6'd0;
    assign wprod = 13'(wave * r_vol[ci]);
    assign acc   = {1'b0, r_sum} + {5'd0, wprod};

    assign o_sts.ch_end    = (r_cnt >= NCH);
    assign o_sts.ch_active = r_active[ci];
    assign o_sts.ch_runs   = (r_count != '0) && (r_len[ci] != '0);
    assign o_sts.div_done  = (r_steps == '0);

    assign o_out.read_data  = (r_func == FN_READ && r_q_vld) ? r_mem_q : 8'd0;
    assign o_out.mix_sample = (r_func != FN_TICK) ? 16'd0 :
                              (r_sum[16] ? 16'hFFFF : r_sum[15:0]);

endmodule
